/* design/pisac_pkg.sv */
package pisac_pkg;

  localparam int IdWidth = 32;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_CHECK  = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_REFUSED = 2'd1;
  localparam logic [1:0] STAT_DENIED  = 2'd2;
  localparam logic [1:0] STAT_ALLOWED = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

/* design/protected_id_set_with_access_check_top.sv */
// Channel   Direction  Transfer when      Signals
// request   in         start && !busy     mode, target_id, caller_id
// result    out        done (one cycle)   status, hit, hit_index, entry_count
//
// All cells compare in the transfer cycle, and the store is updated in the
// following execute cycle. The result is registered from the execute cycle and
// shown in the same cycle as busy falls, when a new request may already be
// transferred. Reset clears the count, the done flag and the controller; the
// store itself needs no clearing. The receiver cannot stall the result.
module protected_id_set_with_access_check_top #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] target_id,
  input  logic [31:0] caller_id,
  output logic        done,
  output logic [1:0]  status,
  output logic        hit,
  output logic [3:0]  hit_index,
  output logic [4:0]  entry_count
);
  import pisac_pkg::*;

  cmd_t cmd;

  pisac_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  pisac_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .target_id   (target_id),
    .caller_id   (caller_id),
    .done        (done),
    .status      (status),
    .hit         (hit),
    .hit_index   (hit_index),
    .entry_count (entry_count)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_single_exec: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done)
    else $error("execute phase did not end with a result");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a preceding execute cycle");

  a_no_hit_index: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> hit_index == 4'd0)
    else $error("hit_index set without a hit");
`endif

endmodule

/* design/pisac_ctrl.sv */
module pisac_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output pisac_pkg::cmd_t  cmd
);
  import pisac_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

/* design/pisac_datapath.sv */
module pisac_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pisac_pkg::cmd_t                 cmd,
  input  logic [1:0]                      mode,
  input  logic [pisac_pkg::IdWidth-1:0]   target_id,
  input  logic [pisac_pkg::IdWidth-1:0]   caller_id,
  output logic                            done,
  output logic [1:0]                      status,
  output logic                            hit,
  output logic [3:0]                      hit_index,
  output logic [4:0]                      entry_count
);
  import pisac_pkg::*;

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);

  logic [IdWidth-1:0] id_store [ENTRIES];
  logic [CNTW-1:0]    count;
  logic [CNTW-1:0]    count_next;

  logic [ENTRIES-1:0] match_now;
  logic [ENTRIES-1:0] match;
  logic [1:0]         mode_q;
  logic [IdWidth-1:0] target_q;
  logic [IdWidth-1:0] caller_q;

  logic [IDXW-1:0]    hit_idx;
  logic               hit_any;
  logic               do_insert;
  logic               do_remove;
  logic [1:0]         status_next;
  logic [IDXW+3:0]    idx_ext;
  logic [CNTW+4:0]    cnt_ext;

  // Every cell compares against the incoming identifier in the cycle of the transfer.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_now[i] = (id_store[i] == target_id) && (CNTW'(i) < count) &&
                     (target_id != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      match    <= match_now;
      mode_q   <= mode;
      target_q <= target_id;
      caller_q <= caller_id;
    end
  end

  // Entries are unique, so the match vector is one-hot or empty.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IDXW'(i);
      end
    end
  end

  assign hit_any = |match;

  always_comb begin
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    count_next  = count;
    status_next = STAT_REFUSED;
    case (mode_q)
      MODE_INSERT: begin
        if (target_q != '0 && !hit_any && count < CNTW'(ENTRIES)) begin
          do_insert   = 1'b1;
          count_next  = count + CNTW'(1);
          status_next = STAT_DONE;
        end
      end
      MODE_REMOVE: begin
        if (hit_any) begin
          do_remove   = 1'b1;
          count_next  = count - CNTW'(1);
          status_next = STAT_DONE;
        end
      end
      MODE_CHECK: begin
        status_next = (hit_any && target_q != caller_q) ? STAT_DENIED : STAT_ALLOWED;
      end
      default: begin
        status_next = STAT_REFUSED;
      end
    endcase
  end

  // A cell takes the appended ID, or on removal, unless last, its upper neighbour.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.execute) begin
        if (do_insert && CNTW'(g) == count) begin
          id_store[g] <= target_q;
        end
        if (g < ENTRIES - 1) begin
          if (do_remove && IDXW'(g) >= hit_idx) begin
            id_store[g] <= id_store[(g < ENTRIES - 1) ? g + 1 : g];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.execute;
      if (cmd.execute) begin
        count <= count_next;
      end
    end
  end

  assign idx_ext = {4'b0, hit_idx};
  assign cnt_ext = {5'b0, count_next};

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status      <= status_next;
      hit         <= hit_any;
      hit_index   <= idx_ext[3:0];
      entry_count <= cnt_ext[4:0];
    end
  end

endmodule
